// ===== hdl/bctd_pkg.sv =====
// Shared types and constants for the block-compressed texel decoder.
package bctd_pkg;

    // Block format codes carried on the kind input
    localparam logic [1:0] KIND_DXT1  = 2'd0;
    localparam logic [1:0] KIND_DXT3  = 2'd1;
    localparam logic [1:0] KIND_DXT5  = 2'd2;
    localparam logic [1:0] KIND_UNSUP = 2'd3;

    // Colour path result handed to the top level
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       black;
    } t_color;

endpackage

// ===== hdl/bc_texel_decoder_unit.sv =====
// Top level of the texel decoder: input register, colour and alpha paths, result register.
// Decodes one texel of a DXT1, DXT3 or DXT5 block to 8-bit RGBA. A transaction is taken at
// every edge where i_start is high; o_busy stays low, so one texel can enter each clock.
// The result passes the input register and then the result register, and appears
// on o_red, o_green, o_blue and o_alpha, qualified by o_done for exactly one cycle. There
// is no hold-off on the result side: a result must be captured in the cycle o_done is high.
// No state links one texel to the next.
module bc_texel_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_endpoint_zero,
    input  logic [15:0] i_endpoint_one,
    input  logic [31:0] i_color_indices,
    input  logic [63:0] i_alpha_bits,
    input  logic [1:0]  i_texel_x,
    input  logic [1:0]  i_texel_y,
    output logic        o_done,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha
);

    logic              r_in_vld;
    logic [1:0]        r_kind;
    logic [15:0]       r_endpoint_zero;
    logic [15:0]       r_endpoint_one;
    logic [31:0]       r_color_indices;
    logic [63:0]       r_alpha_bits;
    logic [3:0]        r_idx;

    logic              r_done;
    logic [7:0]        r_red;
    logic [7:0]        r_green;
    logic [7:0]        r_blue;
    logic [7:0]        r_alpha;

    logic [7:0]        n_red;
    logic [7:0]        n_green;
    logic [7:0]        n_blue;
    logic [7:0]        n_alpha;

    logic [1:0]        sel;
    logic [7:0]        alpha;
    logic              zero;
    bctd_pkg::t_color  color;

    // Never stalls the sender
    assign o_busy = 1'b0;

    // Capture the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_kind          <= i_kind;
            r_endpoint_zero <= i_endpoint_zero;
            r_endpoint_one  <= i_endpoint_one;
            r_color_indices <= i_color_indices;
            r_alpha_bits    <= i_alpha_bits;
            r_idx           <= {i_texel_y, i_texel_x};
        end
    end

    // Colour selector of this texel
    assign sel = r_color_indices[{r_idx, 1'b0} +: 2];

    bctd_color u_color (
        .i_kind          (r_kind),
        .i_endpoint_zero (r_endpoint_zero),
        .i_endpoint_one  (r_endpoint_one),
        .i_sel           (sel),
        .o_color         (color)
    );

    bctd_alpha u_alpha (
        .i_kind       (r_kind),
        .i_alpha_bits (r_alpha_bits),
        .i_idx        (r_idx),
        .o_alpha      (alpha)
    );

    // Drop everything to zero for transparent black or an unsupported format
    always_comb begin
        zero = ((r_kind == bctd_pkg::KIND_DXT1) && color.black) ||
               (r_kind == bctd_pkg::KIND_UNSUP);
        if (zero) begin
            n_red   = 8'd0;
            n_green = 8'd0;
            n_blue  = 8'd0;
            n_alpha = 8'd0;
        end else begin
            n_red   = color.red;
            n_green = color.green;
            n_blue  = color.blue;
            n_alpha = alpha;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_alpha <= n_alpha;
    end

    assign o_done  = r_done;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha;

endmodule

// ===== hdl/bctd_color.sv =====
// Colour path: RGB565 endpoint unpack, palette interpolation and widening to 8 bits.
module bctd_color (
    input  logic [1:0]     i_kind,
    input  logic [15:0]    i_endpoint_zero,
    input  logic [15:0]    i_endpoint_one,
    input  logic [1:0]     i_sel,
    output bctd_pkg::t_color o_color
);

    // Divide an 8-bit value by three: multiply by 171/512, exact up to 255
    function automatic logic [7:0] f_div3(input logic [7:0] x);
        logic [16:0] p;
        p = 17'(x) * 17'd171;
        return p[16:9];
    endfunction

    // One third of the way from p towards q
    function automatic logic [5:0] f_third(input logic [5:0] p, input logic [5:0] q);
        logic [7:0] s;
        logic [7:0] d;
        s = {1'b0, p, 1'b0} + {2'b00, q};
        d = f_div3(s);
        return d[5:0];
    endfunction

    // Truncated mean of two channel values
    function automatic logic [5:0] f_half(input logic [5:0] p, input logic [5:0] q);
        logic [6:0] s;
        s = {1'b0, p} + {1'b0, q};
        return s[6:1];
    endfunction

    // Widen a 5-bit channel: (v*255 + 15) / 31, divide by multiplying with 8457/2^18
    function automatic logic [7:0] f_widen5(input logic [5:0] v);
        logic [12:0] x;
        logic [26:0] p;
        x = 13'(v[4:0]) * 13'd255 + 13'd15;
        p = 27'(x) * 27'd8457;
        return p[25:18];
    endfunction

    // Widen a 6-bit channel: (v*255 + 31) / 63, divide by multiplying with 16645/2^20
    function automatic logic [7:0] f_widen6(input logic [5:0] v);
        logic [13:0] x;
        logic [27:0] p;
        x = 14'(v) * 14'd255 + 14'd31;
        p = 28'(x) * 28'd16645;
        return p[27:20];
    endfunction

    logic [5:0] c0_r, c0_g, c0_b;
    logic [5:0] c1_r, c1_g, c1_b;
    logic [5:0] v_r, v_g, v_b;
    logic       four;
    logic       black;

    // Unpack endpoints, red and blue held in six bits with a zero on top
    assign c0_r = {1'b0, i_endpoint_zero[15:11]};
    assign c0_g = i_endpoint_zero[10:5];
    assign c0_b = {1'b0, i_endpoint_zero[4:0]};
    assign c1_r = {1'b0, i_endpoint_one[15:11]};
    assign c1_g = i_endpoint_one[10:5];
    assign c1_b = {1'b0, i_endpoint_one[4:0]};

    // Four-colour palette unless a DXT1 block has its first endpoint at or below the second
    assign four = (i_kind != bctd_pkg::KIND_DXT1) || (i_endpoint_zero > i_endpoint_one);

    // Pick the palette entry
    always_comb begin
        black = 1'b0;
        v_r   = c0_r;
        v_g   = c0_g;
        v_b   = c0_b;
        case (i_sel)
            2'd0: begin
                v_r = c0_r;
                v_g = c0_g;
                v_b = c0_b;
            end
            2'd1: begin
                v_r = c1_r;
                v_g = c1_g;
                v_b = c1_b;
            end
            2'd2: begin
                if (four) begin
                    v_r = f_third(c0_r, c1_r);
                    v_g = f_third(c0_g, c1_g);
                    v_b = f_third(c0_b, c1_b);
                end else begin
                    v_r = f_half(c0_r, c1_r);
                    v_g = f_half(c0_g, c1_g);
                    v_b = f_half(c0_b, c1_b);
                end
            end
            default: begin
                if (four) begin
                    v_r = f_third(c1_r, c0_r);
                    v_g = f_third(c1_g, c0_g);
                    v_b = f_third(c1_b, c0_b);
                end else begin
                    black = 1'b1;
                end
            end
        endcase
    end

    // Widen to 8 bits with rounding to the nearest step of 255
    assign o_color.red   = f_widen5(v_r);
    assign o_color.green = f_widen6(v_g);
    assign o_color.blue  = f_widen5(v_b);
    assign o_color.black = black;

endmodule

// ===== hdl/bctd_alpha.sv =====
// Alpha path: constant DXT1 alpha, explicit DXT3 alpha and interpolated DXT5 alpha.
module bctd_alpha (
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_alpha_bits,
    input  logic [3:0]  i_idx,
    output logic [7:0]  o_alpha
);

    // Divide an 11-bit value by seven: multiply by 2341/16384, exact up to 1785
    function automatic logic [7:0] f_div7(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd2341;
        return p[21:14];
    endfunction

    // Divide an 11-bit value by five: multiply by 3277/16384, exact up to 1275
    function automatic logic [7:0] f_div5(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd3277;
        return p[21:14];
    endfunction

    logic [3:0]  nib;
    logic [5:0]  sel_base;
    logic [2:0]  sel;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [3:0]  w0;
    logic [2:0]  w1;
    logic [10:0] wsum;
    logic        eight;
    logic [7:0]  dxt5_a;

    // Fetch the texel's explicit nibble and interpolation selector
    assign nib      = i_alpha_bits[{i_idx, 2'b00} +: 4];
    assign sel_base = 6'd16 + 6'(i_idx) * 6'd3;
    assign sel      = i_alpha_bits[sel_base +: 3];
    assign a0       = i_alpha_bits[7:0];
    assign a1       = i_alpha_bits[15:8];
    assign eight    = a0 > a1;

    // Weights for the eight-step or six-step ramp
    always_comb begin
        if (eight) begin
            w0 = 4'd8 - 4'(sel);
        end else begin
            w0 = 4'd6 - 4'(sel);
        end
        w1   = sel - 3'd1;
        wsum = 11'(w0) * 11'(a0) + 11'(w1) * 11'(a1);
    end

    // Select the DXT5 alpha
    always_comb begin
        if (sel == 3'd0) begin
            dxt5_a = a0;
        end else if (sel == 3'd1) begin
            dxt5_a = a1;
        end else if (eight) begin
            dxt5_a = f_div7(wsum);
        end else if (sel == 3'd6) begin
            dxt5_a = 8'd0;
        end else if (sel == 3'd7) begin
            dxt5_a = 8'd255;
        end else begin
            dxt5_a = f_div5(wsum);
        end
    end

    // Choose by block format
    always_comb begin
        unique case (i_kind)
            bctd_pkg::KIND_DXT1: o_alpha = 8'd255;
            bctd_pkg::KIND_DXT3: o_alpha = {nib, nib};
            bctd_pkg::KIND_DXT5: o_alpha = dxt5_a;
            default:             o_alpha = 8'd0;
        endcase
    end

endmodule

// ===== hdl/bctd_checker.sv =====
// Port-level checks for the texel decoder, bound to the top level.
module bctd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic [1:0] i_kind,
    input logic       o_done,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic [7:0] o_alpha
);

    // Every accepted transaction is followed by a result strobe on o_done
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_done)
        else $error("accepted transaction produced no result");

    // No result strobe without an earlier transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 2))
        else $error("result strobe without a transaction");

    // Unsupported format decodes to all zeros
    a_unsup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_kind == bctd_pkg::KIND_UNSUP) |-> ##2
        (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0 && o_alpha == 8'd0))
        else $error("unsupported format gave a non-zero texel");

    // DXT1 alpha is opaque, or transparent with black colour
    a_dxt1_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_kind == bctd_pkg::KIND_DXT1) |-> ##2
        (o_alpha == 8'd255 ||
         (o_alpha == 8'd0 && o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0)))
        else $error("DXT1 texel with invalid alpha");

endmodule

bind bc_texel_decoder_unit bctd_checker u_bctd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .i_kind  (i_kind),
    .o_done  (o_done),
    .o_red   (o_red),
    .o_green (o_green),
    .o_blue  (o_blue),
    .o_alpha (o_alpha)
);
